[hw/rtl/bff_tape_interpreter_top_assert.svh]
// assertion macros shared by the tape interpreter modules
// no dependencies; included by the controller, the datapath and the top level
`ifndef BFF_TAPE_INTERPRETER_TOP_ASSERT_SVH
`define BFF_TAPE_INTERPRETER_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define BTI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bti assertion failed");

// next-cycle implication, disabled while reset is asserted
`define BTI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bti assertion failed");

`endif

[hw/rtl/bti_pkg.sv]
// shared types, opcode constants and decode function for the tape interpreter
// no dependencies; imported by bti_ctrl, bti_datapath and the top level
package bti_pkg;

  localparam int unsigned TapeDepthDefault = 128;
  localparam logic [7:0]  TapeLengthReset  = 8'd128;

  // tape opcodes (ascii)
  localparam logic [7:0] OpHead0Dec = 8'h3C;  // '<'
  localparam logic [7:0] OpHead0Inc = 8'h3E;  // '>'
  localparam logic [7:0] OpHead1Dec = 8'h7B;  // '{'
  localparam logic [7:0] OpHead1Inc = 8'h7D;  // '}'
  localparam logic [7:0] OpByteDec  = 8'h2D;  // '-'
  localparam logic [7:0] OpByteInc  = 8'h2B;  // '+'
  localparam logic [7:0] OpCopyOut  = 8'h2E;  // '.'
  localparam logic [7:0] OpCopyIn   = 8'h2C;  // ','
  localparam logic [7:0] OpOpen     = 8'h5B;  // '['
  localparam logic [7:0] OpClose    = 8'h5D;  // ']'

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_RUN   = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0] command;
    logic [6:0] address;
    logic [7:0] write_data;
  } bti_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       run_done;
  } bti_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RESP,
    ST_FETCH,
    ST_DECODE,
    ST_OPER,
    ST_SCAN_RD,
    ST_SCAN_CHK
  } ctrl_state_e;

  typedef enum logic [3:0] {
    OPC_NOP,
    OPC_H0_DEC,
    OPC_H0_INC,
    OPC_H1_DEC,
    OPC_H1_INC,
    OPC_BYTE_DEC,
    OPC_BYTE_INC,
    OPC_COPY_OUT,
    OPC_COPY_IN,
    OPC_OPEN
  } op_class_e;

  typedef enum logic [1:0] {RD_HOST, RD_PC, RD_H0, RD_H1} rd_sel_e;
  typedef enum logic [1:0] {WA_HOST, WA_H0, WA_H1} wa_sel_e;
  typedef enum logic [1:0] {WD_HOST, WD_INC, WD_DEC, WD_COPY} wd_sel_e;
  typedef enum logic [2:0] {HEAD_NONE, HEAD0_DEC, HEAD0_INC, HEAD1_DEC, HEAD1_INC} head_op_e;

  // controller to datapath
  typedef struct packed {
    logic     host_latch;
    logic     rd_en;
    rd_sel_e  rd_sel;
    logic     wr_en;
    wa_sel_e  wa_sel;
    wd_sel_e  wd_sel;
    logic     pc_clr;
    logic     pc_inc;
    logic     heads_clr;
    head_op_e head_op;
    logic     depth_clr;
    logic     depth_upd;
    logic     rd_result;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic      pc_at_end;
    logic      pc_next_at_end;
    op_class_e op_class;
    logic      data_zero;
    logic      depth_next_zero;
  } dp_status_t;

  function automatic op_class_e decode_op(input logic [7:0] b);
    op_class_e c;
    case (b)
      OpHead0Dec: c = OPC_H0_DEC;
      OpHead0Inc: c = OPC_H0_INC;
      OpHead1Dec: c = OPC_H1_DEC;
      OpHead1Inc: c = OPC_H1_INC;
      OpByteDec:  c = OPC_BYTE_DEC;
      OpByteInc:  c = OPC_BYTE_INC;
      OpCopyOut:  c = OPC_COPY_OUT;
      OpCopyIn:   c = OPC_COPY_IN;
      OpOpen:     c = OPC_OPEN;
      default:    c = OPC_NOP;
    endcase
    return c;
  endfunction

endpackage

[hw/rtl/bti_datapath.sv]
// tape memory, heads, program pointer, bracket depth and length register
// depends on bti_pkg and bff_tape_interpreter_top_assert.svh
`include "bff_tape_interpreter_top_assert.svh"

module bti_datapath #(
  parameter int unsigned TAPE_DEPTH = bti_pkg::TapeDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  bti_pkg::bti_in_t    in_item_i,
  input  bti_pkg::dp_cmd_t    cmd_i,
  output bti_pkg::dp_status_t status_o,
  output logic [7:0]          read_data_o
);
  import bti_pkg::*;

  localparam int unsigned AW = $clog2(TAPE_DEPTH);
  localparam int unsigned PW = $clog2(TAPE_DEPTH + 1);
  localparam logic [15:0] DepthW = 16'(TAPE_DEPTH);

  logic [7:0]    mem_q [TAPE_DEPTH];
  logic [7:0]    rdata_q;
  logic [7:0]    tape_length_q;
  logic [AW-1:0] h0_q, h0_d, h1_q, h1_d;
  logic [PW-1:0] pc_q, pc_d;
  logic [PW-1:0] depth_q, depth_d, depth_nx;
  logic          host_ok_q;

  logic [15:0]   addr_w, tl_w, len_w;
  logic          host_ok;
  logic [AW-1:0] host_idx, rd_idx, wr_idx;
  logic [7:0]    wr_data;
  logic          wr_en_eff;
  logic [PW-1:0] len_eff, last;
  logic [PW:0]   pc_p1;

  // host address and effective length
  assign addr_w   = {9'b0, in_item_i.address};
  assign host_ok  = addr_w < DepthW;
  assign host_idx = addr_w[AW-1:0];
  assign tl_w     = {8'b0, tape_length_q};
  assign len_w    = (tl_w == 16'd0) ? 16'd1 : ((tl_w > DepthW) ? DepthW : tl_w);
  assign len_eff  = len_w[PW-1:0];
  assign last     = len_eff - PW'(1);
  assign pc_p1    = {1'b0, pc_q} + (PW+1)'(1);

  always_comb begin
    case (cmd_i.rd_sel)
      RD_HOST: rd_idx = host_idx;
      RD_PC:   rd_idx = AW'(pc_q);
      RD_H0:   rd_idx = h0_q;
      RD_H1:   rd_idx = h1_q;
      default: rd_idx = host_idx;
    endcase
    case (cmd_i.wa_sel)
      WA_HOST: wr_idx = host_idx;
      WA_H0:   wr_idx = h0_q;
      WA_H1:   wr_idx = h1_q;
      default: wr_idx = host_idx;
    endcase
    case (cmd_i.wd_sel)
      WD_HOST: wr_data = in_item_i.write_data;
      WD_INC:  wr_data = rdata_q + 8'd1;
      WD_DEC:  wr_data = rdata_q - 8'd1;
      WD_COPY: wr_data = rdata_q;
      default: wr_data = rdata_q;
    endcase
  end

  assign wr_en_eff = cmd_i.wr_en && ((cmd_i.wa_sel != WA_HOST) || host_ok);

  always_ff @(posedge clk_i) begin
    if (wr_en_eff) begin
      mem_q[wr_idx] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_idx];
    end
  end

  // bracket nesting during a forward skip
  always_comb begin
    depth_nx = depth_q;
    if (rdata_q == OpOpen) begin
      depth_nx = depth_q + PW'(1);
    end else if (rdata_q == OpClose && depth_q != '0) begin
      depth_nx = depth_q - PW'(1);
    end
  end

  always_comb begin
    h0_d    = h0_q;
    h1_d    = h1_q;
    pc_d    = pc_q;
    depth_d = depth_q;
    if (cmd_i.heads_clr) begin
      h0_d = '0;
      h1_d = '0;
    end else begin
      case (cmd_i.head_op)
        HEAD0_DEC: if (h0_q != '0) h0_d = h0_q - AW'(1);
        HEAD0_INC: if (PW'(h0_q) < last) h0_d = h0_q + AW'(1);
        HEAD1_DEC: if (h1_q != '0) h1_d = h1_q - AW'(1);
        HEAD1_INC: if (PW'(h1_q) < last) h1_d = h1_q + AW'(1);
        default: ;
      endcase
    end
    if (cmd_i.pc_clr) begin
      pc_d = '0;
    end else if (cmd_i.pc_inc) begin
      pc_d = pc_p1[PW-1:0];
    end
    if (cmd_i.depth_clr) begin
      depth_d = '0;
    end else if (cmd_i.depth_upd) begin
      depth_d = depth_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tape_length_q <= TapeLengthReset;
      h0_q          <= '0;
      h1_q          <= '0;
      pc_q          <= '0;
      depth_q       <= '0;
      host_ok_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tape_length_q <= cfg_wdata_i;
      end
      if (cmd_i.host_latch) begin
        host_ok_q <= host_ok;
      end
      h0_q    <= h0_d;
      h1_q    <= h1_d;
      pc_q    <= pc_d;
      depth_q <= depth_d;
    end
  end

  assign status_o.pc_at_end       = pc_q >= len_eff;
  assign status_o.pc_next_at_end  = pc_p1 >= {1'b0, len_eff};
  assign status_o.op_class        = decode_op(rdata_q);
  assign status_o.data_zero       = rdata_q == 8'd0;
  assign status_o.depth_next_zero = depth_nx == '0;

  assign read_data_o = (cmd_i.rd_result && host_ok_q) ? rdata_q : 8'd0;

  `BTI_ASSERT_NEXT(a_run_start_clears, clk_i, rst_ni, cmd_i.pc_clr, (pc_q == '0) && (h0_q == '0) && (h1_q == '0))
  `BTI_ASSERT_NEXT(a_head0_single_step, clk_i, rst_ni, cmd_i.head_op == HEAD0_INC && !cmd_i.heads_clr, (h0_q == $past(h0_q)) || (h0_q == AW'($past(h0_q) + AW'(1))))

endmodule

[hw/rtl/bti_ctrl.sv]
// sequencer for host commands and the tape program run
// depends on bti_pkg and bff_tape_interpreter_top_assert.svh
`include "bff_tape_interpreter_top_assert.svh"

module bti_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [1:0]          command_i,
  input  bti_pkg::dp_status_t status_i,
  output bti_pkg::dp_cmd_t    cmd_o,
  output logic                busy_o,
  output logic                strobe_o,
  output logic                run_done_o
);
  import bti_pkg::*;

  ctrl_state_e state_q, state_d;
  cmd_e        kind_q, kind_d;
  op_class_e   op_q, op_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= CMD_NONE;
      op_q    <= OPC_NOP;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    op_d    = op_q;
    cmd_o   = '{host_latch: 1'b0, rd_en: 1'b0, rd_sel: RD_HOST, wr_en: 1'b0,
                wa_sel: WA_HOST, wd_sel: WD_HOST, pc_clr: 1'b0, pc_inc: 1'b0,
                heads_clr: 1'b0, head_op: HEAD_NONE, depth_clr: 1'b0,
                depth_upd: 1'b0, rd_result: 1'b0};
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          kind_d           = cmd_e'(command_i);
          cmd_o.host_latch = 1'b1;
          state_d          = ST_RESP;
          case (cmd_e'(command_i))
            CMD_WRITE: cmd_o.wr_en = 1'b1;
            CMD_READ:  cmd_o.rd_en = 1'b1;
            CMD_RUN: begin
              cmd_o.pc_clr    = 1'b1;
              cmd_o.heads_clr = 1'b1;
              state_d         = ST_FETCH;
            end
            default: ;
          endcase
        end
      end
      ST_RESP: begin
        cmd_o.rd_result = kind_q == CMD_READ;
        state_d         = ST_IDLE;
      end
      ST_FETCH: begin
        if (status_i.pc_at_end) begin
          state_d = ST_RESP;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_PC;
          state_d      = ST_DECODE;
        end
      end
      ST_DECODE: begin
        op_d = status_i.op_class;
        case (status_i.op_class)
          OPC_H0_DEC, OPC_H0_INC, OPC_H1_DEC, OPC_H1_INC: begin
            case (status_i.op_class)
              OPC_H0_DEC: cmd_o.head_op = HEAD0_DEC;
              OPC_H0_INC: cmd_o.head_op = HEAD0_INC;
              OPC_H1_DEC: cmd_o.head_op = HEAD1_DEC;
              default:    cmd_o.head_op = HEAD1_INC;
            endcase
            cmd_o.pc_inc = 1'b1;
            state_d      = ST_FETCH;
          end
          OPC_BYTE_DEC, OPC_BYTE_INC, OPC_COPY_OUT, OPC_OPEN: begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RD_H0;
            state_d      = ST_OPER;
          end
          OPC_COPY_IN: begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RD_H1;
            state_d      = ST_OPER;
          end
          default: begin
            cmd_o.pc_inc = 1'b1;
            state_d      = ST_FETCH;
          end
        endcase
      end
      ST_OPER: begin
        cmd_o.pc_inc = 1'b1;
        state_d      = ST_FETCH;
        case (op_q)
          OPC_BYTE_INC: begin
            cmd_o.wr_en  = 1'b1;
            cmd_o.wa_sel = WA_H0;
            cmd_o.wd_sel = WD_INC;
          end
          OPC_BYTE_DEC: begin
            cmd_o.wr_en  = 1'b1;
            cmd_o.wa_sel = WA_H0;
            cmd_o.wd_sel = WD_DEC;
          end
          OPC_COPY_OUT: begin
            cmd_o.wr_en  = 1'b1;
            cmd_o.wa_sel = WA_H1;
            cmd_o.wd_sel = WD_COPY;
          end
          OPC_COPY_IN: begin
            cmd_o.wr_en  = 1'b1;
            cmd_o.wa_sel = WA_H0;
            cmd_o.wd_sel = WD_COPY;
          end
          OPC_OPEN: begin
            if (status_i.data_zero) begin
              // skip starts at the open bracket itself
              cmd_o.pc_inc    = 1'b0;
              cmd_o.depth_clr = 1'b1;
              state_d         = ST_SCAN_RD;
            end
          end
          default: ;
        endcase
      end
      ST_SCAN_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_PC;
        state_d      = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        cmd_o.depth_upd = 1'b1;
        cmd_o.pc_inc    = 1'b1;
        if (status_i.depth_next_zero) begin
          state_d = ST_FETCH;
        end else if (status_i.pc_next_at_end) begin
          state_d = ST_RESP;
        end else begin
          state_d = ST_SCAN_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o     = state_q != ST_IDLE;
  assign strobe_o   = state_q == ST_RESP;
  assign run_done_o = (state_q == ST_RESP) && (kind_q == CMD_RUN);

  `BTI_ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni, state_q == ST_IDLE && start_i, busy_o)
  `BTI_ASSERT_NEXT(a_beat_then_idle, clk_i, rst_ni, strobe_o, !busy_o)
  `BTI_ASSERT_NEXT(a_run_end_reports, clk_i, rst_ni, state_q == ST_FETCH && status_i.pc_at_end, strobe_o && run_done_o)

endmodule

[hw/rtl/bff_tape_interpreter_top.sv]
// top level of the self-modifying byte tape interpreter
// depends on bti_pkg, bti_ctrl and bti_datapath
`include "bff_tape_interpreter_top_assert.svh"

// a command is taken when start is high and busy is low. every command gives
// exactly one result beat, shown for a single cycle with result_strobe_o high;
// the receiver cannot stall, so it must capture the beat in that cycle.
// write, read and the unused command pass through acceptance and the result
// beat (a read sees the tape through the registered memory port). a run passes
// through acceptance, the end-of-tape check and the result beat plus, for each
// tape byte executed, a fetch and a decode step for head moves and no-ops and a
// fetch, a decode and an operate step for + - . , and [. when the byte at head0
// is zero, a [ adds a read and a check step for every byte scanned, the [ itself
// and its matching ] included; a scan that runs off the end of the tape skips
// the end-of-tape check. the user must write tape_length through cfg_we_i /
// cfg_wdata_i only while busy is low; the block itself does not enforce this.
// a value of 0 acts as 1 and a value above TAPE_DEPTH acts as TAPE_DEPTH. tape
// bytes come out of reset undefined and must be written before they are read
// or run.
module bff_tape_interpreter_top #(
  parameter int unsigned TAPE_DEPTH = bti_pkg::TapeDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // command beat
  input  logic              start,
  output logic              busy,
  input  bti_pkg::bti_in_t  in_item_i,
  // result beat
  output logic              result_strobe_o,
  output bti_pkg::bti_out_t result_o,
  // tape_length register
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i
);
  import bti_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;
  logic [7:0] read_data;
  logic       run_done;

  // sequencer: decodes host commands and steps the tape program
  bti_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .command_i  (in_item_i.command),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd),
    .busy_o     (busy),
    .strobe_o   (result_strobe_o),
    .run_done_o (run_done)
  );

  // tape memory, heads, program pointer and length register
  bti_datapath #(
    .TAPE_DEPTH (TAPE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .read_data_o (read_data)
  );

  // both result fields are zero outside the result beat
  assign result_o.read_data = read_data;
  assign result_o.run_done  = run_done;

endmodule

[tb/sv/bff_tape_interpreter_checker.sv]
`timescale 1ns / 1ps
// scoreboard for the tape interpreter: mirrors the tape and the length register,
// predicts one result beat per accepted command and compares the strobed beats
// depends on bti_pkg only
module bff_tape_interpreter_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  bti_pkg::bti_in_t  item_i,
  input  logic              strobe_i,
  input  bti_pkg::bti_out_t result_i,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  output int                pending_o,
  output int                fail_count_o
);
  import bti_pkg::*;

  localparam int unsigned TapeCells = TapeDepthDefault;

  logic [7:0] tape_img [TapeCells];
  logic [7:0] length_reg;
  bti_out_t   due_q [$];
  int         fails = 0;

  // one forward pass over the live part of the tape image
  function automatic void run_tape_image();
    int unsigned span, last, pc, h0, h1, depth;
    span = (length_reg == 8'd0) ? 1 : ((length_reg > TapeCells) ? TapeCells : length_reg);
    last = span - 1;
    pc = 0;
    h0 = 0;
    h1 = 0;
    while (pc < span) begin
      case (tape_img[pc])
        OpHead0Dec: if (h0 > 0) h0--;
        OpHead0Inc: if (h0 < last) h0++;
        OpHead1Dec: if (h1 > 0) h1--;
        OpHead1Inc: if (h1 < last) h1++;
        OpByteDec:  tape_img[h0] = tape_img[h0] - 8'd1;
        OpByteInc:  tape_img[h0] = tape_img[h0] + 8'd1;
        OpCopyOut:  tape_img[h1] = tape_img[h0];
        OpCopyIn:   tape_img[h0] = tape_img[h1];
        OpOpen: begin
          // zero under head0: skip to the matching close, or off the end
          if (tape_img[h0] == 8'h00) begin
            depth = 0;
            while (pc < span) begin
              if (tape_img[pc] == OpOpen) depth++;
              else if (tape_img[pc] == OpClose && depth > 0) depth--;
              if (depth == 0) break;
              pc++;
            end
          end
        end
        default: ;
      endcase
      pc++;
    end
  endfunction

  function automatic bti_out_t predict_beat(input bti_in_t it);
    bti_out_t r;
    r = '0;
    case (cmd_e'(it.command))
      CMD_WRITE: tape_img[it.address] = it.write_data;
      CMD_READ:  r.read_data = tape_img[it.address];
      CMD_RUN: begin
        run_tape_image();
        r.run_done = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    bti_out_t want;
    if (!rst_ni) begin
      due_q.delete();
      foreach (tape_img[i]) tape_img[i] = 8'h00;
      length_reg = TapeLengthReset;
      fails = 0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (strobe_i) begin
        if (due_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: result beat with nothing outstanding: read_data=%02h run_done=%0b",
                     $time, result_i.read_data, result_i.run_done);
        end else begin
          want = due_q.pop_front();
          if (result_i.read_data !== want.read_data || result_i.run_done !== want.run_done) begin
            fails++;
            if (fails <= 10)
              $display("%0t: mismatch: expected read_data=%02h run_done=%0b, got %02h %0b",
                       $time, want.read_data, want.run_done,
                       result_i.read_data, result_i.run_done);
          end
        end
      end
      if (cfg_we_i) length_reg = cfg_wdata_i;
      if (start_i && !busy_i) due_q.push_back(predict_beat(item_i));
      pending_o <= due_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

[tb/sv/bff_tape_interpreter_top_tb.sv]
`timescale 1ns / 1ps
// testbench top for the tape interpreter: clock, reset, command beats, length
// settings and the verdict; depends on bti_pkg, the block and its checker
module bff_tape_interpreter_top_tb;
  import bti_pkg::*;

  localparam int unsigned TargetItems = 1050;
  // slowest legal run is roughly 1050 full-tape runs plus gaps
  localparam int unsigned CycleLimit  = 2_000_000;
  // longest single command is a full-tape run, so wait that long at the end
  localparam int unsigned DrainCycles = 460;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  bti_in_t    in_item;
  logic       result_strobe;
  bti_out_t   result;
  logic       cfg_we;
  logic [7:0] cfg_wdata;
  int         pending;
  int         fail_count;

  int unsigned cycles = 0;
  int unsigned items_done = 0;
  int unsigned n_write = 0, n_read = 0, n_run = 0, n_unused = 0, n_settings = 0;
  // tb copy of the length register, used to aim program writes at live bytes
  logic [7:0] length_now = TapeLengthReset;

  bff_tape_interpreter_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .in_item_i       (in_item),
    .result_strobe_o (result_strobe),
    .result_o        (result),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  bff_tape_interpreter_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .item_i       (in_item),
    .strobe_i     (result_strobe),
    .result_i     (result),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // watchdog: a hung handshake or a lost result ends the run here
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("Some tests failed");
      $finish;
    end
  end

  // tape content biased toward opcodes and zero bytes so that runs move the
  // heads, modify the tape and take brackets; the rest is any byte value
  function automatic logic [7:0] random_tape_byte();
    logic [7:0] opcodes [10];
    int unsigned pick;
    opcodes = '{OpHead0Dec, OpHead0Inc, OpHead1Dec, OpHead1Inc, OpByteDec,
                OpByteInc, OpCopyOut, OpCopyIn, OpOpen, OpClose};
    pick = $urandom_range(0, 99);
    if (pick < 60) return opcodes[$urandom_range(0, 9)];
    if (pick < 75) return 8'h00;
    return 8'($urandom);
  endfunction

  // one command beat: optional idle cycles, then hold start until busy is low
  // at a rising edge. start is only touched at falling edges, once per edge.
  task automatic issue(input cmd_e cmd, input logic [6:0] addr, input logic [7:0] data);
    @(negedge clk_i);
    // idle about 35% of cycles, except in a gap-free stretch of the run
    while (!(items_done >= 400 && items_done < 600) && $urandom_range(0, 99) < 35) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start   <= 1'b1;
    in_item <= '{command: cmd, address: addr, write_data: data};
    do @(posedge clk_i); while (busy);
    case (cmd)
      CMD_WRITE: n_write++;
      CMD_READ:  n_read++;
      CMD_RUN:   n_run++;
      default:   n_unused++;
    endcase
    if (cmd != CMD_NONE) items_done++;
  endtask

  // length register write: only once every result is back and busy is low
  task automatic set_length(input logic [7:0] value);
    @(negedge clk_i);
    start <= 1'b0;
    do @(posedge clk_i); while (busy || pending != 0);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    length_now = value;
    n_settings++;
  endtask

  // a well-formed sequence: patch a few live bytes, run, read some back
  task automatic program_burst();
    int unsigned span;
    span = (length_now == 8'd0) ? 1 :
           ((length_now > TapeDepthDefault) ? TapeDepthDefault : length_now);
    repeat ($urandom_range(1, 6))
      issue(CMD_WRITE, 7'($urandom_range(0, span - 1)), random_tape_byte());
    issue(CMD_RUN, 7'($urandom), 8'($urandom));
    // reads mostly inside the live span, sometimes anywhere in the store
    repeat ($urandom_range(0, 2))
      issue(CMD_READ, ($urandom_range(0, 3) == 0) ? 7'($urandom)
                                                  : 7'($urandom_range(0, span - 1)),
            8'($urandom));
  endtask

  initial begin : stimulus
    logic [7:0] lengths [6];
    int unsigned phase;
    lengths = '{8'd1, 8'd128, 8'd0, 8'd255, 8'd129, 8'd2};

    rst_ni    = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = 8'h00;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // tape bytes are undefined out of reset: write every one before any read or run
    for (int a = 0; a < TapeDepthDefault; a++)
      issue(CMD_WRITE, 7'(a), random_tape_byte());

    // unused command with all ones, then all zeros: no effect, empty result
    issue(CMD_NONE, 7'h7F, 8'hFF);
    issue(CMD_NONE, 7'h00, 8'h00);
    // full run at the reset length, then with a length above the tape depth
    issue(CMD_RUN, 7'h00, 8'h00);
    set_length(8'd255);
    issue(CMD_RUN, 7'h7F, 8'hFF);
    // field extremes
    issue(CMD_WRITE, 7'h7F, 8'hFF);
    issue(CMD_READ, 7'h7F, 8'h00);
    issue(CMD_WRITE, 7'h00, 8'h00);
    issue(CMD_READ, 7'h00, 8'h00);
    // two-byte tape: decrement wraps 00 to ff, increment wraps it back
    set_length(8'd2);
    issue(CMD_WRITE, 7'd1, OpByteDec);
    issue(CMD_RUN, 7'd0, 8'h00);
    issue(CMD_READ, 7'd0, 8'h00);
    issue(CMD_WRITE, 7'd1, OpByteInc);
    issue(CMD_RUN, 7'd0, 8'h00);
    issue(CMD_READ, 7'd0, 8'h00);
    // length 0 behaves as a one-byte tape
    set_length(8'd0);
    issue(CMD_RUN, 7'd0, 8'h00);
    issue(CMD_READ, 7'd0, 8'h00);
    // zero under head0: nested brackets are skipped, increment inside never runs
    set_length(8'd6);
    issue(CMD_WRITE, 7'd1, OpOpen);
    issue(CMD_WRITE, 7'd2, OpOpen);
    issue(CMD_WRITE, 7'd3, OpClose);
    issue(CMD_WRITE, 7'd4, OpByteInc);
    issue(CMD_WRITE, 7'd5, OpClose);
    issue(CMD_RUN, 7'd0, 8'h00);
    issue(CMD_READ, 7'd0, 8'h00);
    // drop the outer close: the skip runs off the end and the run finishes
    issue(CMD_WRITE, 7'd5, OpHead0Inc);
    issue(CMD_RUN, 7'd0, 8'h00);
    issue(CMD_READ, 7'd0, 8'h00);

    // random phases, each under a new length; mostly program bursts, some noise
    phase = 0;
    while (items_done < TargetItems) begin
      set_length(phase < 6 ? lengths[phase] :
                 ($urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(1, 128))));
      repeat ($urandom_range(4, 12)) begin
        if ($urandom_range(0, 99) < 75) program_burst();
        else repeat ($urandom_range(1, 4))
          issue(cmd_e'($urandom_range(0, 3)), 7'($urandom), 8'($urandom));
      end
      phase++;
    end

    @(negedge clk_i);
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    // catch stray beats after the last expected one
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d writes, %0d reads, %0d tape runs, %0d unused commands",
             n_write, n_read, n_run, n_unused);
    $display("across %0d length settings in %0d cycles, %0d failures",
             n_settings, cycles, fail_count);
    if (fail_count == 0 && pending == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

[bff_tape_interpreter_top.f]
+incdir+hw/rtl
hw/rtl/bti_pkg.sv
hw/rtl/bti_datapath.sv
hw/rtl/bti_ctrl.sv
hw/rtl/bff_tape_interpreter_top.sv
tb/sv/bff_tape_interpreter_checker.sv
tb/sv/bff_tape_interpreter_top_tb.sv
